FILE: sv/sha1md_pkg.sv
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared types and constants of the SHA-1 message digest block.
// ----------------------------------------------------------------------------
package sha1md_pkg;

    // working variables a..e of the compression, also used for the chain value
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } t_abcde;

    // initial chaining value
    localparam t_abcde IV = '{
        a: 32'h6745_2301,
        b: 32'hEFCD_AB89,
        c: 32'h98BA_DCFE,
        d: 32'h1032_5476,
        e: 32'hC3D2_E1F0
    };

    // round constants, one per group of twenty rounds
    localparam logic [31:0] K_00_19 = 32'h5A82_7999;
    localparam logic [31:0] K_20_39 = 32'h6ED9_EBA1;
    localparam logic [31:0] K_40_59 = 32'h8F1B_BCDC;
    localparam logic [31:0] K_60_79 = 32'hCA62_C1D6;

    // padding marker byte
    localparam logic [7:0] PAD_BYTE = 8'h80;

    // round numbering
    localparam logic [6:0] LAST_ROUND  = 7'd79;
    localparam int unsigned ROUND_BITS = 7;

endpackage

FILE: sv/sha1md_in_if.sv
// ----------------------------------------------------------------------------
// sha1md_in_if
// Message byte channel: valid/ready handshake with one byte item per transfer.
// ----------------------------------------------------------------------------
interface sha1md_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] message_byte;
    logic       byte_valid;
    logic       end_of_message;

    modport source (output valid, output message_byte, output byte_valid,
                    output end_of_message, input ready);
    modport sink   (input valid, input message_byte, input byte_valid,
                    input end_of_message, output ready);
endinterface

FILE: sv/sha1md_out_if.sv
// ----------------------------------------------------------------------------
// sha1md_out_if
// Digest word channel: valid/ready handshake with one digest word per transfer.
// ----------------------------------------------------------------------------
interface sha1md_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_position;
    logic        final_word;
    logic        too_long;

    modport source (output valid, output digest_word, output word_position,
                    output final_word, output too_long, input ready);
    modport sink   (input valid, input digest_word, input word_position,
                    input final_word, input too_long, output ready);
endinterface

FILE: sv/sha1md_round.sv
// ----------------------------------------------------------------------------
// sha1md_round
// One SHA-1 round: selects f and k by round number and updates a..e.
// ----------------------------------------------------------------------------
module sha1md_round
    import sha1md_pkg::*;
(
    input  t_abcde                  i_cur,
    input  logic [ROUND_BITS-1:0]   i_round,
    input  logic [31:0]             i_w,
    output t_abcde                  o_nxt
);

    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] tmp;

    // round function and constant by group of twenty
    always_comb begin
        if (i_round < 7'd20) begin
            f = (i_cur.b & i_cur.c) | (~i_cur.b & i_cur.d);
            k = K_00_19;
        end else if (i_round < 7'd40) begin
            f = i_cur.b ^ i_cur.c ^ i_cur.d;
            k = K_20_39;
        end else if (i_round < 7'd60) begin
            f = (i_cur.b & i_cur.c) | (i_cur.b & i_cur.d) | (i_cur.c & i_cur.d);
            k = K_40_59;
        end else begin
            f = i_cur.b ^ i_cur.c ^ i_cur.d;
            k = K_60_79;
        end
    end

    // new a from rotated a, f, e, schedule word and constant
    assign tmp = {i_cur.a[26:0], i_cur.a[31:27]} + f + i_cur.e + i_w + k;

    assign o_nxt.a = tmp;
    assign o_nxt.b = i_cur.a;
    assign o_nxt.c = {i_cur.b[1:0], i_cur.b[31:2]};
    assign o_nxt.d = i_cur.c;
    assign o_nxt.e = i_cur.d;

endmodule

FILE: sv/sha1_message_digest.sv
// ----------------------------------------------------------------------------
// sha1_message_digest
// Byte-serial SHA-1 engine with padding and a buffered five-word digest output.
// ----------------------------------------------------------------------------
// A byte item is taken in only in S_IDLE. The byte that completes a 64-byte
// block starts a compression: a load step (S_CSTART), 80 rounds that each
// pass through S_RD_A, S_RD_B and S_EXEC, and a fold of the result into the
// chain value (S_ADD). The round rate is set by the 16-word schedule memory,
// whose two read ports deliver the four schedule words of a round over two
// registered reads. An end-of-message item then writes padding words, runs
// one compression, or two when 56 or more bytes are pending, and moves the
// digest into the output buffer. The five digest words leave from that buffer
// while the next message is already being taken in; a second digest waits only
// if the buffer has not been emptied yet. A message byte that arrives after the
// bit length has wrapped is dropped and the digest reports too_long.
module sha1_message_digest
    import sha1md_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    sha1md_in_if.sink       i_msg,
    sha1md_out_if.source    o_dig
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CSTART,
        S_RD_A,
        S_RD_B,
        S_EXEC,
        S_ADD,
        S_PAD_FIRST,
        S_ZERO,
        S_LEN_HI,
        S_LEN_LO,
        S_FIN
    } t_state;

    // where to go after a compression
    typedef enum logic [1:0] {
        RET_IDLE,
        RET_PAD,
        RET_PAD2,
        RET_OUT
    } t_ret;

    t_state                 r_state;
    t_ret                   r_ret;
    logic [ROUND_BITS-1:0]  r_t;
    logic [5:0]             r_fill;
    logic [23:0]            r_acc;
    logic [63:0]            r_len;
    logic                   r_ovf;
    t_abcde                 r_chain;
    t_abcde                 r_rr;
    logic [31:0]            r_xa;
    logic [4:0]             r_wi;
    logic                   r_two;

    // schedule memory, also holds the block being filled
    logic [31:0]            r_mem [16];
    logic [31:0]            r_q0;
    logic [31:0]            r_q1;

    // output buffer
    logic [31:0]            r_dout [5];
    logic                   r_out_too;
    logic [2:0]             r_out_pos;
    logic                   r_out_busy;

    logic                   in_xfer;
    logic                   out_xfer;
    logic                   store_byte;
    logic [64:0]            n_len_sum;
    logic                   mem_we;
    logic [3:0]             mem_waddr;
    logic [31:0]            mem_wdata;
    logic [3:0]             rd_addr0;
    logic [3:0]             rd_addr1;
    logic [31:0]            sched_w;
    logic [31:0]            pad_word;
    logic [31:0]            mix;
    logic [4:0]             zero_limit;
    t_abcde                 rr_nxt;

    // handshakes
    assign i_msg.ready = (r_state == S_IDLE);
    assign in_xfer     = i_msg.valid && i_msg.ready;
    assign out_xfer    = o_dig.valid && o_dig.ready;
    assign store_byte  = in_xfer && i_msg.byte_valid && !r_ovf;

    assign n_len_sum   = {1'b0, r_len} + 65'd8;

    // schedule expansion word of the current round
    assign mix     = r_xa ^ r_q0 ^ r_q1;
    assign sched_w = (r_t < 7'd16) ? r_q1 : {mix[30:0], mix[31]};

    // word that carries the padding marker
    always_comb begin
        case (r_fill[1:0])
            2'd0:    pad_word = {PAD_BYTE, 24'h0};
            2'd1:    pad_word = {r_acc[7:0], PAD_BYTE, 16'h0};
            2'd2:    pad_word = {r_acc[15:0], PAD_BYTE, 8'h0};
            default: pad_word = {r_acc[23:0], PAD_BYTE};
        endcase
    end

    assign zero_limit = r_two ? 5'd16 : 5'd14;

    // memory read addresses
    always_comb begin
        if (r_state == S_RD_B) begin
            rd_addr0 = r_t[3:0] - 4'd14;
            rd_addr1 = r_t[3:0];
        end else begin
            rd_addr0 = r_t[3:0] - 4'd3;
            rd_addr1 = r_t[3:0] - 4'd8;
        end
    end

    // memory write port
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_t[3:0];
        mem_wdata = sched_w;
        case (r_state)
            S_IDLE: begin
                mem_we    = store_byte && (r_fill[1:0] == 2'd3);
                mem_waddr = r_fill[5:2];
                mem_wdata = {r_acc, i_msg.message_byte};
            end
            S_EXEC: begin
                mem_we    = 1'b1;
            end
            S_PAD_FIRST: begin
                mem_we    = 1'b1;
                mem_waddr = r_fill[5:2];
                mem_wdata = pad_word;
            end
            S_ZERO: begin
                mem_we    = (r_wi != zero_limit);
                mem_waddr = r_wi[3:0];
                mem_wdata = 32'h0;
            end
            S_LEN_HI: begin
                mem_we    = 1'b1;
                mem_waddr = 4'd14;
                mem_wdata = r_len[63:32];
            end
            S_LEN_LO: begin
                mem_we    = 1'b1;
                mem_waddr = 4'd15;
                mem_wdata = r_len[31:0];
            end
            default: begin
                mem_we    = 1'b0;
            end
        endcase
    end

    // schedule memory with registered reads
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_q0 <= r_mem[rd_addr0];
        r_q1 <= r_mem[rd_addr1];
    end

    // round datapath
    sha1md_round u_round (
        .i_cur   (r_rr),
        .i_round (r_t),
        .i_w     (sched_w),
        .o_nxt   (rr_nxt)
    );

    // control, chain value and output buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ret      <= RET_IDLE;
            r_fill     <= 6'd0;
            r_len      <= 64'd0;
            r_ovf      <= 1'b0;
            r_chain    <= IV;
            r_rr       <= '0;
            r_out_busy <= 1'b0;
            r_out_pos  <= 3'd0;
        end else begin
            // digest words leave from the front of the buffer
            if (out_xfer) begin
                r_dout[0] <= r_dout[1];
                r_dout[1] <= r_dout[2];
                r_dout[2] <= r_dout[3];
                r_dout[3] <= r_dout[4];
                r_out_pos <= r_out_pos + 3'd1;
                if (r_out_pos == 3'd4) begin
                    r_out_busy <= 1'b0;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (store_byte) begin
                        r_acc  <= {r_acc[15:0], i_msg.message_byte};
                        r_fill <= r_fill + 6'd1;
                        r_len  <= n_len_sum[63:0];
                        if (n_len_sum[64]) begin
                            r_ovf <= 1'b1;
                        end
                        if (r_fill == 6'd63) begin
                            r_ret   <= i_msg.end_of_message ? RET_PAD : RET_IDLE;
                            r_state <= S_CSTART;
                        end else if (i_msg.end_of_message) begin
                            r_state <= S_PAD_FIRST;
                        end
                    end else if (in_xfer && i_msg.end_of_message) begin
                        r_state <= S_PAD_FIRST;
                    end
                end
                S_CSTART: begin
                    r_rr    <= r_chain;
                    r_t     <= '0;
                    r_state <= S_RD_A;
                end
                S_RD_A: begin
                    r_state <= S_RD_B;
                end
                S_RD_B: begin
                    r_xa    <= r_q0 ^ r_q1;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_rr <= rr_nxt;
                    if (r_t == LAST_ROUND) begin
                        r_state <= S_ADD;
                    end else begin
                        r_t     <= r_t + 7'd1;
                        r_state <= S_RD_A;
                    end
                end
                S_ADD: begin
                    r_chain.a <= r_chain.a + r_rr.a;
                    r_chain.b <= r_chain.b + r_rr.b;
                    r_chain.c <= r_chain.c + r_rr.c;
                    r_chain.d <= r_chain.d + r_rr.d;
                    r_chain.e <= r_chain.e + r_rr.e;
                    case (r_ret)
                        RET_IDLE: r_state <= S_IDLE;
                        RET_PAD:  r_state <= S_PAD_FIRST;
                        RET_PAD2: begin
                            r_wi    <= 5'd0;
                            r_two   <= 1'b0;
                            r_state <= S_ZERO;
                        end
                        default:  r_state <= S_FIN;
                    endcase
                end
                S_PAD_FIRST: begin
                    r_wi    <= {1'b0, r_fill[5:2]} + 5'd1;
                    r_two   <= (r_fill[5:2] >= 4'd14);
                    r_state <= S_ZERO;
                end
                S_ZERO: begin
                    if (r_wi == zero_limit) begin
                        if (r_two) begin
                            r_ret   <= RET_PAD2;
                            r_state <= S_CSTART;
                        end else begin
                            r_state <= S_LEN_HI;
                        end
                    end else begin
                        r_wi <= r_wi + 5'd1;
                    end
                end
                S_LEN_HI: begin
                    r_state <= S_LEN_LO;
                end
                S_LEN_LO: begin
                    r_ret   <= RET_OUT;
                    r_state <= S_CSTART;
                end
                S_FIN: begin
                    // hand the digest over and start a fresh message
                    if (!r_out_busy) begin
                        r_dout[0]  <= r_chain.a;
                        r_dout[1]  <= r_chain.b;
                        r_dout[2]  <= r_chain.c;
                        r_dout[3]  <= r_chain.d;
                        r_dout[4]  <= r_chain.e;
                        r_out_too  <= r_ovf;
                        r_out_pos  <= 3'd0;
                        r_out_busy <= 1'b1;
                        r_chain    <= IV;
                        r_fill     <= 6'd0;
                        r_len      <= 64'd0;
                        r_ovf      <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output channel
    assign o_dig.valid         = r_out_busy;
    assign o_dig.digest_word   = r_dout[0];
    assign o_dig.word_position = r_out_pos;
    assign o_dig.final_word    = (r_out_pos == 3'd4);
    assign o_dig.too_long      = r_out_too;

endmodule

FILE: sv/sha1md_checker.sv
// ----------------------------------------------------------------------------
// sha1md_checker
// Port-level checks of the digest output sequence, bound to the top level.
// ----------------------------------------------------------------------------
module sha1md_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_digest_word,
    input  logic [2:0]  i_word_position,
    input  logic        i_final_word,
    input  logic        i_too_long
);

    // words of one digest come in order
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_final_word) |=>
            (i_out_valid && i_word_position == $past(i_word_position) + 3'd1))
        else $error("digest word position did not advance by one");

    // final word flag marks position four only
    a_final_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_final_word == (i_word_position == 3'd4)))
        else $error("final word flag and position disagree");

    // too-long flag is the same across one digest
    a_too_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_final_word) |=>
            (i_too_long == $past(i_too_long)))
        else $error("too-long flag changed within a digest");

    // a new digest starts at position zero
    a_new_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_final_word) |=>
            (!i_out_valid || i_word_position == 3'd0))
        else $error("digest did not start at position zero");

    // a stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_digest_word)))
        else $error("stalled digest word changed");

endmodule

bind sha1_message_digest sha1md_checker u_sha1md_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_dig.valid),
    .i_out_ready     (o_dig.ready),
    .i_digest_word   (o_dig.digest_word),
    .i_word_position (o_dig.word_position),
    .i_final_word    (o_dig.final_word),
    .i_too_long      (o_dig.too_long)
);
